// ----- rtl/rlfs_pkg.sv -----
// Shared types and constants of the result line field splitter.
package rlfs_pkg;

  localparam int COL_W   = 8;
  localparam int OFS_W   = 12;
  localparam int FOUND_W = 9;
  localparam int EXP_W   = 9;
  localparam int HEAD_W  = 32;

  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;

  localparam logic [HEAD_W-1:0] NULL_WORD = 32'h4E55_4C4C;

  localparam logic KIND_FIELD = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [1:0] ADDR_EXPECTED_COLUMNS = 2'd0;
  localparam logic [EXP_W-1:0] EXPECTED_COLUMNS_RESET = 9'd1;

  // Depth of both queues; must be a power of two.
  localparam int QUEUE_DEPTH = 4;

  // One classified byte handed from the front part to the back part.
  typedef struct packed {
    logic       proc;      // held byte goes through the splitter
    logic       last;      // the line ends with this item
    logic       ovl;       // line ran past the maximum length
    logic [7:0] data;
    logic       is_space;  // tab, comma or space
    logic       is_comma;
    logic       is_quote;
    logic       is_bslash;
  } op_t;

  typedef struct packed {
    logic               record_kind;
    logic [COL_W-1:0]   column_index;
    logic [OFS_W-1:0]   token_start;
    logic [OFS_W-1:0]   token_length;
    logic               is_missing;
    logic               was_quoted;
    logic               column_overflow;
    logic [FOUND_W-1:0] columns_found;
    logic               line_short;
    logic               line_too_long;
  } rec_t;

endpackage

// ----- rtl/rlfs_fifo.sv -----
// Small register queue used between the parts of the field splitter.
module rlfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/rlfs_front.sv -----
// Front part: takes bytes, holds one back, tracks line length and classifies.
module rlfs_front #(
  parameter int LINE_MAX = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    line_byte,
  input  logic          line_end,
  output logic          full,
  output logic          op_push,
  output rlfs_pkg::op_t op_data,
  input  logic          op_full
);
  import rlfs_pkg::*;

  localparam int POS_W = $clog2(LINE_MAX + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic             overlong_r, overlong_nxt;
  logic             accept, ovl_now, proc;

  assign full    = op_full;
  assign accept  = push & ~op_full;
  assign ovl_now = overlong_r | (pos_r >= POS_W'(LINE_MAX));
  // The first two bytes of a line are never split.
  assign proc    = ~ovl_now & held_valid_r & (pos_r >= POS_W'(3));

  always_comb begin
    op_data.proc      = proc;
    op_data.last      = line_end;
    op_data.ovl       = ovl_now;
    op_data.data      = held_byte_r;
    op_data.is_comma  = (held_byte_r == CHR_COMMA);
    op_data.is_space  = (held_byte_r == CHR_TAB) || (held_byte_r == CHR_COMMA) ||
                        (held_byte_r == CHR_SPACE);
    op_data.is_quote  = (held_byte_r == CHR_QUOTE);
    op_data.is_bslash = (held_byte_r == CHR_BSLASH);
    op_push           = accept & (proc | line_end);
  end

  always_comb begin
    pos_nxt        = pos_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    overlong_nxt   = overlong_r;
    if (accept) begin
      if (line_end) begin
        pos_nxt        = '0;
        held_byte_nxt  = '0;
        held_valid_nxt = 1'b0;
        overlong_nxt   = 1'b0;
      end else begin
        overlong_nxt = ovl_now;
        if (!ovl_now) begin
          held_byte_nxt  = line_byte;
          held_valid_nxt = 1'b1;
          pos_nxt        = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      held_byte_r  <= '0;
      held_valid_r <= 1'b0;
      overlong_r   <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      overlong_r   <= overlong_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(LINE_MAX))
    else $error("line position ran past the maximum line length");
`endif

endmodule

// ----- rtl/rlfs_back.sv -----
// Back part: the gap/token/quoted/escaped splitter that builds the records.
module rlfs_back #(
  parameter int LINE_MAX    = 4096,
  parameter int MAX_COLUMNS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rlfs_pkg::EXP_W-1:0]  expected_columns,
  input  logic                        op_valid,
  input  rlfs_pkg::op_t               op_data,
  output logic                        op_pop,
  input  logic                        out_full,
  output logic                        out_push,
  output rlfs_pkg::rec_t              out_rec
);
  import rlfs_pkg::*;

  localparam int POS_W = $clog2(LINE_MAX + 1);
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

  localparam logic [1:0] ST_GAP     = 2'd0;
  localparam logic [1:0] ST_TOKEN   = 2'd1;
  localparam logic [1:0] ST_QUOTED  = 2'd2;
  localparam logic [1:0] ST_ESCAPED = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic              cq_r, cq_nxt;
  logic              fq_r, fq_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  rec_t              pend_rec_r, pend_rec_nxt;

  logic [POS_W-1:0]  diff, len;
  logic [HEAD_W-1:0] head_step;
  rec_t              rec0, rec1;
  logic              rec0_v, rec1_v;

  assign op_pop    = op_valid & ~pend_valid_r & ~out_full;
  assign diff      = pos_r - start_r;
  assign head_step = (diff < POS_W'(4)) ? {head_r[HEAD_W-9:0], op_data.data} : head_r;
  assign len       = diff - POS_W'(cq_r);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    cq_nxt    = cq_r;
    fq_nxt    = fq_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    rec0      = '0;
    rec1      = '0;
    rec0_v    = 1'b0;
    rec1_v    = 1'b0;

    if (op_pop && op_data.proc) begin
      pos_nxt = pos_r + POS_W'(1);
      case (state_r)
        ST_GAP: begin
          if (!op_data.is_space) begin
            if (op_data.is_quote) begin
              state_nxt = ST_QUOTED;
              start_nxt = pos_r + POS_W'(1);
              fq_nxt    = 1'b1;
              head_nxt  = '0;
            end else begin
              state_nxt = ST_TOKEN;
              start_nxt = pos_r;
              fq_nxt    = 1'b0;
              head_nxt  = {{(HEAD_W-8){1'b0}}, op_data.data};
            end
          end
        end
        ST_TOKEN: begin
          head_nxt = head_step;
          // The second to last byte of the line closes the field like a comma.
          if (op_data.is_comma || op_data.last) begin
            rec0_v               = 1'b1;
            rec0.record_kind     = KIND_FIELD;
            rec0.column_index    = (32'(count_r) > 32'(255)) ? 8'hFF : COL_W'(count_r);
            rec0.token_start     = OFS_W'(start_r);
            rec0.token_length    = OFS_W'(len);
            rec0.is_missing      = (len == '0) ||
                                   ((len == POS_W'(4)) && (head_step == NULL_WORD));
            rec0.was_quoted      = fq_r;
            rec0.column_overflow = (32'(count_r) >= 32'(expected_columns)) ||
                                   (32'(count_r) >= 32'(MAX_COLUMNS));
            if (32'(count_r) < 32'(MAX_COLUMNS)) begin
              count_nxt = count_r + CNT_W'(1);
            end
            cq_nxt    = 1'b0;
            fq_nxt    = 1'b0;
            state_nxt = ST_GAP;
          end
        end
        ST_QUOTED: begin
          head_nxt = head_step;
          if (op_data.is_quote) begin
            state_nxt = ST_TOKEN;
            cq_nxt    = 1'b1;
          end else if (op_data.is_bslash) begin
            state_nxt = ST_ESCAPED;
          end
        end
        default: begin
          head_nxt  = head_step;
          state_nxt = ST_QUOTED;
        end
      endcase
    end

    if (op_pop && op_data.last) begin
      rec1_v             = 1'b1;
      rec1.record_kind   = KIND_END;
      rec1.columns_found = FOUND_W'(count_nxt);
      rec1.line_short    = (32'(count_nxt) < 32'(expected_columns));
      rec1.line_too_long = op_data.ovl;
      state_nxt = ST_GAP;
      pos_nxt   = POS_W'(2);
      start_nxt = POS_W'(2);
      cq_nxt    = 1'b0;
      fq_nxt    = 1'b0;
      count_nxt = '0;
      head_nxt  = '0;
    end
  end

  // A line end that also closes a field parks its end record until the result queue has room.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_rec_nxt   = pend_rec_r;
    if (pend_valid_r) begin
      out_push       = ~out_full;
      out_rec        = pend_rec_r;
      pend_valid_nxt = out_full;
    end else begin
      out_push = op_pop & (rec0_v | rec1_v);
      out_rec  = rec0_v ? rec0 : rec1;
      if (op_pop && rec0_v && rec1_v) begin
        pend_valid_nxt = 1'b1;
        pend_rec_nxt   = rec1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_rec_r <= pend_rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_GAP;
      pos_r        <= POS_W'(2);
      start_r      <= POS_W'(2);
      cq_r         <= 1'b0;
      fq_r         <= 1'b0;
      count_r      <= '0;
      head_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      start_r      <= start_nxt;
      cq_r         <= cq_nxt;
      fq_r         <= fq_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pend_after_field: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_valid_r) |-> $past(out_push) && !$past(out_rec.record_kind))
    else $error("end record parked without a field record going out first");

  a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_COLUMNS))
    else $error("column count ran past its saturation limit");

  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (op_pop && op_data.last) |=>
      (state_r == ST_GAP) && (count_r == '0) && (pos_r == POS_W'(2)))
    else $error("splitter did not return to line start after a line end");
`endif

endmodule

// ----- rtl/result_line_field_splitter_top.sv -----
// Top level of the result line field splitter: queues, front, back and register.
// A byte's field record is built once the next byte is accepted, then goes through the
// operand queue, back part and result queue; the end record trails any field it closes.
// Throughput: one byte per cycle unless a queue is full; a line end closing a field holds
// the back part while its end record waits; the result queue takes one record per cycle.
// Reset (rst_n low, synchronous) empties both queues, clears line state and sets
// expected_columns to 1.
module result_line_field_splitter_top #(
  parameter int LINE_MAX    = 4096,
  parameter int MAX_COLUMNS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_line_byte,
  input  logic        in_line_end,
  output logic        empty,
  input  logic        pop,
  output logic        out_record_kind,
  output logic [7:0]  out_column_index,
  output logic [11:0] out_token_start,
  output logic [11:0] out_token_length,
  output logic        out_is_missing,
  output logic        out_was_quoted,
  output logic        out_column_overflow,
  output logic [8:0]  out_columns_found,
  output logic        out_line_short,
  output logic        out_line_too_long,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rlfs_pkg::*;

  logic [EXP_W-1:0] exp_cols_r, exp_cols_nxt;
  logic             op_push, op_full, op_empty, op_pop;
  op_t              op_wdata, op_rdata;
  logic             rec_push, rec_full;
  rec_t             rec_wdata, rec_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_EXPECTED_COLUMNS) ? {{(32-EXP_W){1'b0}}, exp_cols_r} : '0;

  always_comb begin
    exp_cols_nxt = exp_cols_r;
    if (psel && penable && pwrite && pready && (paddr == ADDR_EXPECTED_COLUMNS)) begin
      exp_cols_nxt = pwdata[EXP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cols_r <= EXPECTED_COLUMNS_RESET;
    end else begin
      exp_cols_r <= exp_cols_nxt;
    end
  end

  rlfs_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .line_byte (in_line_byte),
    .line_end  (in_line_end),
    .full      (full),
    .op_push   (op_push),
    .op_data   (op_wdata),
    .op_full   (op_full)
  );

  rlfs_fifo #(.WIDTH($bits(op_t)), .DEPTH(QUEUE_DEPTH)) u_op_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (op_wdata),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_rdata),
    .empty (op_empty)
  );

  rlfs_back #(.LINE_MAX(LINE_MAX), .MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .expected_columns (exp_cols_r),
    .op_valid         (~op_empty),
    .op_data          (op_rdata),
    .op_pop           (op_pop),
    .out_full         (rec_full),
    .out_push         (rec_push),
    .out_rec          (rec_wdata)
  );

  rlfs_fifo #(.WIDTH($bits(rec_t)), .DEPTH(QUEUE_DEPTH)) u_rec_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (rec_wdata),
    .full  (rec_full),
    .pop   (pop),
    .rdata (rec_rdata),
    .empty (empty)
  );

  assign out_record_kind     = rec_rdata.record_kind;
  assign out_column_index    = rec_rdata.column_index;
  assign out_token_start     = rec_rdata.token_start;
  assign out_token_length    = rec_rdata.token_length;
  assign out_is_missing      = rec_rdata.is_missing;
  assign out_was_quoted      = rec_rdata.was_quoted;
  assign out_column_overflow = rec_rdata.column_overflow;
  assign out_columns_found   = rec_rdata.columns_found;
  assign out_line_short      = rec_rdata.line_short;
  assign out_line_too_long   = rec_rdata.line_too_long;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the result line field splitter: line stimulus, prediction and checking.
`timescale 1ns / 1ps

module testbench;
  import rlfs_pkg::*;

  localparam int LINE_LIMIT   = 4096;
  localparam int COLUMN_LIMIT = 256;
  localparam logic [7:0] CHR_OPEN  = 8'h5B;
  localparam logic [7:0] CHR_CLOSE = 8'h5D;

  typedef enum logic [1:0] {
    SPLIT_GAP, SPLIT_TOKEN, SPLIT_QUOTED, SPLIT_ESCAPED
  } split_e;

  // Predicts the field and end records of each line and checks them in order.
  class field_scoreboard;
    rec_t             pending[$];
    logic [EXP_W-1:0] exp_cols;
    int unsigned      line_pos;
    logic [7:0]       held;
    logic             held_ok;
    split_e           st;
    int unsigned      fstart;
    logic             close_q;
    logic             quoted;
    int unsigned      ncols;
    logic [31:0]      head;
    logic             ovl;
    int               errors;

    function new();
      exp_cols = EXPECTED_COLUMNS_RESET;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_pos = 0;
      held = '0;
      held_ok = 1'b0;
      st = SPLIT_GAP;
      fstart = 2;
      close_q = 1'b0;
      quoted = 1'b0;
      ncols = 0;
      head = '0;
      ovl = 1'b0;
    endfunction

    function void split(logic [7:0] c, int unsigned p, logic penult);
      int unsigned len;
      rec_t r;
      if (p < 2) return;
      if (st == SPLIT_GAP) begin
        if (c != CHR_TAB && c != CHR_COMMA && c != CHR_SPACE) begin
          if (c == CHR_QUOTE) begin
            st = SPLIT_QUOTED;
            fstart = p + 1;
            quoted = 1'b1;
            head = '0;
          end else begin
            st = SPLIT_TOKEN;
            fstart = p;
            quoted = 1'b0;
            head = {24'b0, c};
          end
        end
        return;
      end
      // Only the first four bytes of a field matter for the NULL test.
      if (p - fstart < 4) head = {head[23:0], c};
      case (st)
        SPLIT_TOKEN: begin
          if (c == CHR_COMMA || penult) begin
            len = p - fstart - close_q;
            r = '0;
            r.record_kind = KIND_FIELD;
            r.column_index = (ncols > 255) ? 8'd255 : ncols[7:0];
            r.token_start = fstart[11:0];
            r.token_length = len[11:0];
            r.is_missing = (len == 0) || (len == 4 && head == NULL_WORD);
            r.was_quoted = quoted;
            r.column_overflow = (ncols >= exp_cols) || (ncols >= COLUMN_LIMIT);
            pending.push_back(r);
            if (ncols < COLUMN_LIMIT) ncols++;
            close_q = 1'b0;
            quoted = 1'b0;
            st = SPLIT_GAP;
          end
        end
        SPLIT_ESCAPED: st = SPLIT_QUOTED;
        default: begin
          if (c == CHR_QUOTE) begin
            st = SPLIT_TOKEN;
            close_q = 1'b1;
          end else if (c == CHR_BSLASH) begin
            st = SPLIT_ESCAPED;
          end
        end
      endcase
    endfunction

    // One byte is held back, so the byte processed now learns whether it is second to last.
    function void note_byte(logic [7:0] b, logic last);
      rec_t r;
      if (!ovl && line_pos >= LINE_LIMIT) ovl = 1'b1;
      if (!ovl && held_ok) split(held, line_pos - 1, last);
      if (last) begin
        r = '0;
        r.record_kind = KIND_END;
        r.columns_found = ncols[8:0];
        r.line_short = ncols < exp_cols;
        r.line_too_long = ovl;
        pending.push_back(r);
        clear_line();
      end else if (!ovl) begin
        held = b;
        held_ok = 1'b1;
        line_pos++;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check(rec_t got);
      rec_t want;
      if (pending.size() == 0) begin
        report($sformatf("record %h arrived with nothing expected", got));
        return;
      end
      want = pending.pop_front();
      compare("record_kind", got.record_kind, want.record_kind);
      compare("column_index", got.column_index, want.column_index);
      compare("token_start", got.token_start, want.token_start);
      compare("token_length", got.token_length, want.token_length);
      compare("is_missing", got.is_missing, want.is_missing);
      compare("was_quoted", got.was_quoted, want.was_quoted);
      compare("column_overflow", got.column_overflow, want.column_overflow);
      compare("columns_found", got.columns_found, want.columns_found);
      compare("line_short", got.line_short, want.line_short);
      compare("line_too_long", got.line_too_long, want.line_too_long);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_line_byte;
  logic        in_line_end;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_record_kind;
  logic [7:0]  out_column_index;
  logic [11:0] out_token_start;
  logic [11:0] out_token_length;
  logic        out_is_missing;
  logic        out_was_quoted;
  logic        out_column_overflow;
  logic [8:0]  out_columns_found;
  logic        out_line_short;
  logic        out_line_too_long;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  field_scoreboard book;
  logic [7:0]      line_bytes[$];
  int              send_idle;
  int              recv_stall;
  int              sent;

  result_line_field_splitter_top #(
    .LINE_MAX(LINE_LIMIT),
    .MAX_COLUMNS(COLUMN_LIMIT)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_line_byte(in_line_byte), .in_line_end(in_line_end),
    .empty(empty), .pop(pop),
    .out_record_kind(out_record_kind), .out_column_index(out_column_index),
    .out_token_start(out_token_start), .out_token_length(out_token_length),
    .out_is_missing(out_is_missing), .out_was_quoted(out_was_quoted),
    .out_column_overflow(out_column_overflow), .out_columns_found(out_columns_found),
    .out_line_short(out_line_short), .out_line_too_long(out_line_too_long),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) book.note_byte(in_line_byte, in_line_end);
      if (pop && !empty)
        book.check({out_record_kind, out_column_index, out_token_start, out_token_length,
                    out_is_missing, out_was_quoted, out_column_overflow,
                    out_columns_found, out_line_short, out_line_too_long});
    end
  end

  initial begin
    #20_000_000;
    $display("result_line_field_splitter_top regression: fail");
    $finish;
  end

  function void add_field(int max_len);
    int n;
    logic [7:0] b;
    n = $urandom_range(1, max_len);
    case ($urandom_range(9))
      0: for (int k = 3; k >= 0; k--) line_bytes.push_back(NULL_WORD[8*k +: 8]);
      1: begin
        line_bytes.push_back(CHR_QUOTE);
        line_bytes.push_back(CHR_QUOTE);
      end
      2, 3: begin
        line_bytes.push_back(CHR_QUOTE);
        repeat (n) begin
          if ($urandom_range(4) == 0) begin
            line_bytes.push_back(CHR_BSLASH);
            line_bytes.push_back(8'($urandom_range(255)));
          end else begin
            do b = 8'($urandom_range(255)); while (b == CHR_QUOTE || b == CHR_BSLASH);
            line_bytes.push_back(b);
          end
        end
        line_bytes.push_back(CHR_QUOTE);
        // Bytes after the closing quote stay in the same field.
        if ($urandom_range(3) == 0) begin
          do b = 8'($urandom_range(255)); while (b == CHR_COMMA);
          line_bytes.push_back(b);
        end
      end
      default: begin
        do b = 8'($urandom_range(255));
        while (b == CHR_TAB || b == CHR_COMMA || b == CHR_SPACE || b == CHR_QUOTE);
        line_bytes.push_back(b);
        repeat (n - 1) begin
          do b = 8'($urandom_range(255)); while (b == CHR_COMMA);
          line_bytes.push_back(b);
        end
      end
    endcase
  endfunction

  // Builds a bracketed line; a nonzero target adds fields up to that exact length.
  function void compose(int nfields, int max_len, int pad, int target);
    int i;
    line_bytes = {};
    line_bytes.push_back(CHR_OPEN);
    line_bytes.push_back(CHR_SPACE);
    repeat (pad) line_bytes.push_back(CHR_SPACE);
    i = 0;
    while (i < nfields || (target > 0 && line_bytes.size() < target - 2)) begin
      if (i > 0) begin
        line_bytes.push_back(CHR_COMMA);
        case ($urandom_range(2))
          0: line_bytes.push_back(CHR_SPACE);
          1: line_bytes.push_back(CHR_TAB);
          default: ;
        endcase
      end
      add_field(max_len);
      i++;
    end
    if (target > 0)
      while (line_bytes.size() > target - 2) void'(line_bytes.pop_back());
    line_bytes.push_back(CHR_TAB);
    line_bytes.push_back(CHR_CLOSE);
  endfunction

  task send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    in_line_byte = b;
    in_line_end = last;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i], i == line_bytes.size() - 1);
    sent += line_bytes.size();
  endtask

  task reg_access(logic write, logic [1:0] addr, logic [31:0] wdata, output logic [31:0] rdata);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = write;
    paddr = addr;
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task wait_idle();
    push = 1'b0;
    while (book.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [EXP_W-1:0] setting;
    logic [31:0]      rd;
    int               n;
    book = new();
    rst_n = 1'b0;
    push = 1'b0;
    in_line_byte = '0;
    in_line_end = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 0;
    recv_stall = 0;
    sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: setting = 4;
          2: setting = 0;
          3: setting = 256;
          4: setting = 511;
          default: setting = EXP_W'($urandom_range(2, 9));
        endcase
        reg_access(1'b1, ADDR_EXPECTED_COLUMNS, {23'b0, setting}, rd);
        book.exp_cols = setting;
        reg_access(1'b0, ADDR_EXPECTED_COLUMNS, '0, rd);
        if (rd != {23'b0, setting})
          book.report($sformatf("expected_columns reads %0d, wrote %0d", rd, setting));
      end
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      sent = 0;

      case (p)
        0: begin
          // NULL field, empty quoted field, escaped quote, then tiny lines and a zero byte.
          line_bytes = '{CHR_OPEN, CHR_SPACE, NULL_WORD[31:24], NULL_WORD[23:16],
                         NULL_WORD[15:8], NULL_WORD[7:0], CHR_COMMA, CHR_QUOTE, CHR_QUOTE,
                         CHR_COMMA, CHR_QUOTE, 8'h61, CHR_BSLASH, CHR_QUOTE, 8'h62,
                         CHR_QUOTE, CHR_TAB, CHR_CLOSE};
          send_line();
          line_bytes = '{CHR_CLOSE};
          send_line();
          line_bytes = '{CHR_OPEN, CHR_SPACE, CHR_CLOSE};
          send_line();
          line_bytes = '{CHR_OPEN, CHR_SPACE, 8'h00, CHR_TAB, CHR_CLOSE};
          send_line();
        end
        1: begin
          compose(0, 1500, $urandom_range(0, LINE_LIMIT - 40), LINE_LIMIT);
          send_line();
        end
        2: begin
          compose(COLUMN_LIMIT, 1, 0, 0);
          send_line();
        end
        3: begin
          compose(COLUMN_LIMIT, 1, 0, 0);
          send_line();
          compose(0, 1500, $urandom_range(0, LINE_LIMIT - 40), LINE_LIMIT + 1);
          send_line();
        end
        4: begin
          compose(300, 1, 0, 0);
          send_line();
        end
        default: begin
          compose(0, 2000, $urandom_range(0, 200), LINE_LIMIT + 1 + $urandom_range(1, 300));
          send_line();
        end
      endcase
      sent = 0;

      while (sent < 270) begin
        if ($urandom_range(99) < 80) begin
          compose($urandom_range(0, 7), 12, $urandom_range(0, 2), 0);
        end else begin
          // Noise: short lines, stray quotes and escapes, arbitrary bytes.
          n = $urandom_range(1, 24);
          line_bytes = {};
          repeat (n) begin
            case ($urandom_range(7))
              0: line_bytes.push_back(CHR_QUOTE);
              1: line_bytes.push_back(CHR_BSLASH);
              2: line_bytes.push_back(CHR_COMMA);
              3: line_bytes.push_back($urandom_range(1) ? CHR_TAB : CHR_SPACE);
              default: line_bytes.push_back(8'($urandom_range(255)));
            endcase
          end
        end
        send_line();
      end
    end

    wait_idle();
    if (book.errors == 0) begin
      $display("result_line_field_splitter_top regression: pass");
    end else begin
      $display("result_line_field_splitter_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rlfs_pkg.sv
rtl/rlfs_fifo.sv
rtl/rlfs_front.sv
rtl/rlfs_back.sv
rtl/result_line_field_splitter_top.sv
test/testbench.sv
